FILE: src/mpft_pkg.sv
`default_nettype none
package mpft_pkg;

   // Request codes.
   localparam logic [2:0] REQ_CLEAR  = 3'd0;
   localparam logic [2:0] REQ_PIXEL  = 3'd1;
   localparam logic [2:0] REQ_HLINE  = 3'd2;
   localparam logic [2:0] REQ_RECT   = 3'd3;
   localparam logic [2:0] REQ_GLYPH  = 3'd4;
   localparam logic [2:0] REQ_STRING = 3'd5;
   localparam logic [2:0] REQ_READ   = 3'd6;

   // Glyph geometry and printable code range.
   localparam int GLYPH_COLS   = 5;
   localparam int GLYPH_ROWS   = 7;
   localparam int GLYPH_STRIDE = 6;
   localparam logic [7:0] CODE_LOW  = 8'h20;
   localparam logic [7:0] CODE_HIGH = 8'h7E;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] x_pos;
      logic [15:0] y_pos;
      logic [15:0] span_width;
      logic [15:0] span_height;
      logic        pixel_on;
      logic [7:0]  char_code;
      logic        first_of_string;
      logic [9:0]  byte_address;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       glyph_drawn;
   } rsp_item_type;

   // Font: five column bytes per glyph, leftmost column in the top byte.
   localparam logic [39:0] FONT_TABLE [0:94] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
   };

   // One column byte of a glyph; the spacing column and beyond read as blank.
   function automatic logic [7:0] font_col(input logic [6:0] idx, input logic [2:0] col);
      logic [39:0] g;
      logic [7:0]  b;
      g = FONT_TABLE[idx];
      case (col)
         3'd0:    b = g[39:32];
         3'd1:    b = g[31:24];
         3'd2:    b = g[23:16];
         3'd3:    b = g[15:8];
         3'd4:    b = g[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: src/mpft_ram.sv
`default_nettype none
module mpft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // Single port, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule
`default_nettype wire

FILE: src/mono_page_framebuffer_text_draw.sv
`default_nettype none
// Channel   Ports                     Direction  Handshake
// request   start, busy, req_item     in         taken when start is high and busy is low
// response  rsp_valid, rsp_item       out        one-cycle strobe, always taken
//
// A clear sweeps the store at one byte a cycle, DISPLAY_WIDTH * pages bytes in all.
// Each lit or darkened on-screen pixel is read, then written back, through the single
// memory port; a pixel off the screen is skipped without a write.
// Lines scan DISPLAY_WIDTH columns; rectangles scan two such lines, then
// DISPLAY_HEIGHT rows times two; a glyph walks 42 pixels.
// A read steps through the request, data and response states. The receiver cannot stall.
// After reset the block runs a clearing pass over the whole store with busy high.
module mono_page_framebuffer_text_draw
   import mpft_pkg::*;
#(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item
);

   localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;
   localparam int DEPTH = DISPLAY_WIDTH * PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam int SPAN  = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
   localparam int CW    = $clog2(SPAN);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLEAR  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_WRITE  = 3'd3;
   localparam logic [2:0] S_RDREQ  = 3'd4;
   localparam logic [2:0] S_RDDATA = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   localparam logic [2:0] P_PIXEL = 3'd0;
   localparam logic [2:0] P_LINEA = 3'd1;
   localparam logic [2:0] P_LINEB = 3'd2;
   localparam logic [2:0] P_VERT  = 3'd3;
   localparam logic [2:0] P_GLYPH = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          side_ff, side_in;
   logic [2:0]    gc_ff, gc_in;
   logic [2:0]    gr_ff, gr_in;
   logic [15:0]   x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [15:0]   yb_ff, yb_in, right_ff, right_in;
   logic          on_ff, on_in;
   logic          rect_ff, rect_in;
   logic [6:0]    glyph_ff, glyph_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [7:0]    mask_ff, mask_in;
   logic          color_ff, color_in;
   logic [7:0]    rd_ff, rd_in;
   logic          drawn_ff, drawn_in;
   logic [15:0]   cursor_ff, cursor_in;
   logic          stopped_ff, stopped_in;
   logic          rsp_started_ff, rsp_started_in;

   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata, mem_rdata;

   logic [15:0]   cnt16, px, py, cur_eff;
   logic          cand, color, visible, hit, adv, w_pos, h_pos, stop_eff;
   logic [7:0]    fbits;
   logic [31:0]   pix_addr;
   logic [16:0]   cur_end;

   mpft_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // Candidate pixel of the current drawing phase.
   always_comb begin
      cnt16 = 16'(cnt_ff);
      w_pos = !w_ff[15] && (w_ff != 16'd0);
      h_pos = !h_ff[15] && (h_ff != 16'd0);
      fbits = font_col(glyph_ff, gc_ff);
      px    = x_ff;
      py    = y_ff;
      cand  = 1'b1;
      color = on_ff;
      case (phase_ff)
         P_LINEA: begin
            px   = cnt16;
            cand = w_pos && ((cnt16 - x_ff) < w_ff);
         end
         P_LINEB: begin
            px   = cnt16;
            py   = yb_ff;
            cand = w_pos && ((cnt16 - x_ff) < w_ff);
         end
         P_VERT: begin
            px   = side_ff ? right_ff : x_ff;
            py   = cnt16;
            cand = h_pos && ((cnt16 - y_ff) < h_ff);
         end
         P_GLYPH: begin
            px    = x_ff + 16'(gc_ff);
            py    = y_ff + 16'(gr_ff);
            color = (fbits[gr_ff] && (gc_ff != 3'(GLYPH_COLS))) ? on_ff : !on_ff;
         end
         default: begin
         end
      endcase
      visible  = !px[15] && (px < 16'(DISPLAY_WIDTH)) && !py[15]
                 && (py < 16'(DISPLAY_HEIGHT));
      hit      = cand && visible;
      pix_addr = 32'(py[15:3]) * 32'(DISPLAY_WIDTH) + 32'(px);
   end

   // String cursor decision at request time.
   always_comb begin
      cur_eff  = req_item.first_of_string ? req_item.x_pos : cursor_ff;
      stop_eff = req_item.first_of_string ? 1'b0 : stopped_ff;
      cur_end  = {cur_eff[15], cur_eff} + 17'(GLYPH_COLS);
   end

   // Sequencer next state.
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      side_in    = side_ff;
      gc_in      = gc_ff;
      gr_in      = gr_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      yb_in      = yb_ff;
      right_in   = right_ff;
      on_in      = on_ff;
      rect_in    = rect_ff;
      glyph_in   = glyph_ff;
      addr_in    = addr_ff;
      mask_in    = mask_ff;
      color_in   = color_ff;
      rd_in      = rd_ff;
      drawn_in   = drawn_ff;
      cursor_in  = cursor_ff;
      stopped_in = stopped_ff;
      mem_we     = 1'b0;
      mem_addr   = addr_ff;
      mem_wdata  = 8'h00;
      adv        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in     = req_item.x_pos;
               y_in     = req_item.y_pos;
               w_in     = req_item.span_width;
               h_in     = req_item.span_height;
               on_in    = req_item.pixel_on;
               yb_in    = req_item.y_pos + req_item.span_height - 16'd1;
               right_in = req_item.x_pos + req_item.span_width - 16'd1;
               rect_in  = (req_item.req_type == REQ_RECT);
               glyph_in = ((req_item.char_code < CODE_LOW) || (req_item.char_code > CODE_HIGH))
                          ? 7'd0 : 7'(req_item.char_code - CODE_LOW);
               cnt_in   = '0;
               side_in  = 1'b0;
               gc_in    = 3'd0;
               gr_in    = 3'd0;
               rd_in    = 8'h00;
               drawn_in = 1'b0;
               addr_in  = '0;
               case (req_item.req_type)
                  REQ_CLEAR: state_in = S_CLEAR;
                  REQ_PIXEL: begin
                     phase_in = P_PIXEL;
                     state_in = S_SCAN;
                  end
                  REQ_HLINE, REQ_RECT: begin
                     phase_in = P_LINEA;
                     state_in = S_SCAN;
                  end
                  REQ_GLYPH: begin
                     phase_in = P_GLYPH;
                     state_in = S_SCAN;
                  end
                  REQ_STRING: begin
                     if (stop_eff || ($signed(cur_end) > $signed(17'(DISPLAY_WIDTH)))) begin
                        stopped_in = 1'b1;
                        cursor_in  = cur_eff;
                        state_in   = S_RESP;
                     end else begin
                        stopped_in = 1'b0;
                        cursor_in  = cur_eff + 16'(GLYPH_STRIDE);
                        x_in       = cur_eff;
                        drawn_in   = 1'b1;
                        phase_in   = P_GLYPH;
                        state_in   = S_SCAN;
                     end
                  end
                  REQ_READ: begin
                     if (32'(req_item.byte_address) < 32'(DEPTH)) begin
                        addr_in  = AW'(req_item.byte_address);
                        state_in = S_RDREQ;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         // Zero sweep over the whole store.
         S_CLEAR: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(DEPTH - 1)) begin
               addr_in  = '0;
               state_in = S_RESP;
            end
         end
         // Read the byte of a visible pixel, or skip it.
         S_SCAN: begin
            mem_addr = pix_addr[AW-1:0];
            if (hit) begin
               addr_in  = pix_addr[AW-1:0];
               mask_in  = 8'(1) << py[2:0];
               color_in = color;
               state_in = S_WRITE;
            end else begin
               adv = 1'b1;
            end
         end
         // Write the modified byte back.
         S_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = color_ff ? (mem_rdata | mask_ff) : (mem_rdata & ~mask_ff);
            state_in  = S_SCAN;
            adv       = 1'b1;
         end
         S_RDREQ:  state_in = S_RDDATA;
         S_RDDATA: begin
            rd_in    = mem_rdata;
            state_in = S_RESP;
         end
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase

      // Step to the next candidate pixel of the current shape.
      if (adv) begin
         case (phase_ff)
            P_LINEA: begin
               if (cnt_ff == CW'(DISPLAY_WIDTH - 1)) begin
                  cnt_in = '0;
                  if (rect_ff) begin
                     phase_in = P_LINEB;
                  end else begin
                     state_in = S_RESP;
                  end
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
            P_LINEB: begin
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == CW'(DISPLAY_WIDTH - 1)) begin
                  cnt_in   = '0;
                  side_in  = 1'b0;
                  phase_in = P_VERT;
               end
            end
            P_VERT: begin
               side_in = !side_ff;
               if (side_ff) begin
                  if (cnt_ff == CW'(DISPLAY_HEIGHT - 1)) begin
                     state_in = S_RESP;
                  end else begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
            end
            P_GLYPH: begin
               if (gr_ff == 3'(GLYPH_ROWS - 1)) begin
                  gr_in = 3'd0;
                  if (gc_ff == 3'(GLYPH_COLS)) begin
                     state_in = S_RESP;
                  end else begin
                     gc_in = gc_ff + 3'd1;
                  end
               end else begin
                  gr_in = gr_ff + 3'd1;
               end
            end
            default: state_in = S_RESP;
         endcase
      end
   end

   // Registers; the store is zeroed by a clearing pass after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         addr_ff    <= '0;
         cursor_ff  <= 16'd0;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= (state_ff == S_CLEAR && state_in == S_RESP && !rsp_started_ff)
                       ? S_IDLE : state_in;
         addr_ff    <= addr_in;
         cursor_ff  <= cursor_in;
         stopped_ff <= stopped_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      side_ff  <= side_in;
      gc_ff    <= gc_in;
      gr_ff    <= gr_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      yb_ff    <= yb_in;
      right_ff <= right_in;
      on_ff    <= on_in;
      rect_ff  <= rect_in;
      glyph_ff <= glyph_in;
      mask_ff  <= mask_in;
      color_ff <= color_in;
      rd_ff    <= rd_in;
      drawn_ff <= drawn_in;
   end

   // The clearing pass after reset gives no response; a requested clear does.
   assign rsp_started_in = (state_ff == S_IDLE) ? 1'b1 : rsp_started_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_started_ff <= 1'b0;
      end else begin
         rsp_started_ff <= rsp_started_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_item  = '{read_data: rd_ff, glyph_drawn: drawn_ff};

endmodule
`default_nettype wire

FILE: sim/mono_page_framebuffer_text_draw_checker.sv
`default_nettype none
module mono_page_framebuffer_text_draw_checker
   import mpft_pkg::*;
#(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         busy,
   input  wire req_item_type req_item,
   input  wire logic         rsp_valid,
   input  wire rsp_item_type rsp_item,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGES      = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_SIZE = DISPLAY_WIDTH * PAGES;

   // Shadow copy of the frame store and the text cursor.
   logic [7:0]   shadow_store [0:STORE_SIZE-1];
   logic [15:0]  cursor;
   logic         stopped;
   rsp_item_type expected_words [$];

   function automatic int wrap16(input int v);
      shortint s;
      s = v[15:0];
      return int'(s);
   endfunction

   task automatic plot(input int x, input int y, input bit on);
      int idx;
      if (x < 0 || x >= DISPLAY_WIDTH || y < 0 || y >= DISPLAY_HEIGHT) return;
      idx = (y / 8) * DISPLAY_WIDTH + x;
      if (idx >= STORE_SIZE) return;
      shadow_store[idx][y % 8] = on;
   endtask

   task automatic hline(input int x, input int y, input int w, input bit on);
      for (int i = 0; i < w; i++) plot(wrap16(x + i), y, on);
   endtask

   task automatic glyph(input int x, input int y, input logic [7:0] code, input bit on);
      logic [6:0] idx;
      logic [7:0] bits;
      if (code < CODE_LOW || code > CODE_HIGH) code = CODE_LOW;
      idx = 7'(code - CODE_LOW);
      for (int c = 0; c < GLYPH_COLS; c++) begin
         bits = FONT_TABLE[idx][39 - 8 * c -: 8];
         for (int r = 0; r < GLYPH_ROWS; r++)
            plot(wrap16(x + c), wrap16(y + r), bits[r] ? on : !on);
      end
      for (int r = 0; r < GLYPH_ROWS; r++)
         plot(wrap16(x + GLYPH_COLS), wrap16(y + r), !on);
   endtask

   // Apply one request word to the shadow state and return the expected response word.
   task automatic predict_response(input req_item_type q, output rsp_item_type r);
      int x, y, w, h, right;
      x = wrap16(int'(q.x_pos));
      y = wrap16(int'(q.y_pos));
      w = wrap16(int'(q.span_width));
      h = wrap16(int'(q.span_height));
      r = '0;
      case (q.req_type)
         REQ_CLEAR: begin
            for (int i = 0; i < STORE_SIZE; i++) shadow_store[i] = '0;
         end
         REQ_PIXEL: plot(x, y, q.pixel_on);
         REQ_HLINE: hline(x, y, w, q.pixel_on);
         REQ_RECT: begin
            right = wrap16(x + w - 1);
            hline(x, y, w, q.pixel_on);
            hline(x, wrap16(y + h - 1), w, q.pixel_on);
            for (int i = 0; i < h; i++) begin
               plot(x, wrap16(y + i), q.pixel_on);
               plot(right, wrap16(y + i), q.pixel_on);
            end
         end
         REQ_GLYPH: glyph(x, y, q.char_code, q.pixel_on);
         REQ_STRING: begin
            if (q.first_of_string) begin
               cursor  = q.x_pos;
               stopped = 1'b0;
            end
            if (stopped || wrap16(int'(cursor)) + GLYPH_COLS > DISPLAY_WIDTH) begin
               stopped = 1'b1;
            end else begin
               glyph(wrap16(int'(cursor)), y, q.char_code, q.pixel_on);
               cursor = cursor + 16'(GLYPH_STRIDE);
               r.glyph_drawn = 1'b1;
            end
         end
         REQ_READ: begin
            if (int'(q.byte_address) < STORE_SIZE) r.read_data = shadow_store[q.byte_address];
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
      fail_count++;
   endtask

   // Responses are compared before the new request word of the same edge is queued.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < STORE_SIZE; i++) shadow_store[i] = '0;
         cursor  = '0;
         stopped = 1'b0;
         expected_words.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected response word", 0, int'(rsp_item));
            end else begin
               want = expected_words.pop_front();
               if (rsp_item.read_data !== want.read_data)
                  report_mismatch("read_data", want.read_data, rsp_item.read_data);
               if (rsp_item.glyph_drawn !== want.glyph_drawn)
                  report_mismatch("glyph_drawn", want.glyph_drawn, rsp_item.glyph_drawn);
            end
         end
         if (start && !busy) begin
            predict_response(req_item, want);
            expected_words.push_back(want);
         end
      end
      pending <= expected_words.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end

endmodule
`default_nettype wire

FILE: sim/mono_page_framebuffer_text_draw_tb.sv
`default_nettype none
module mono_page_framebuffer_text_draw_tb;
   import mpft_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   int           fail_count;
   int           pending;
   int           idle_percent;

   mono_page_framebuffer_text_draw uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   mono_page_framebuffer_text_draw_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending(pending)
   );

   // Free-running clock with a 2 ns period.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Build a request word from its fields.
   function automatic req_item_type make_word(input logic [2:0] kind, input int x, input int y,
                                              input int w, input int h, input bit on,
                                              input logic [7:0] code, input bit first,
                                              input logic [9:0] addr);
      req_item_type q;
      q.req_type        = kind;
      q.x_pos           = x[15:0];
      q.y_pos           = y[15:0];
      q.span_width      = w[15:0];
      q.span_height     = h[15:0];
      q.pixel_on        = on;
      q.char_code       = code;
      q.first_of_string = first;
      q.byte_address    = addr;
      return q;
   endfunction

   // Coordinates mostly near the screen, now and then anywhere in 16 bits.
   function automatic int rand_coord(input int lo, input int hi);
      if ($urandom_range(9) == 0) return int'($urandom_range(16'hFFFF, 0));
      return $urandom_range(hi - lo, 0) + lo;
   endfunction

   function automatic req_item_type random_word();
      req_item_type q;
      int pick;
      q = make_word(REQ_READ, rand_coord(-8, 135), rand_coord(-8, 71), rand_coord(-4, 40),
                    rand_coord(-4, 40), 1'($urandom_range(1)), 8'($urandom_range(255)),
                    $urandom_range(4) == 0, 10'($urandom_range(1023)));
      pick = $urandom_range(99);
      if (pick < 2)       q.req_type = REQ_CLEAR;
      else if (pick < 12) q.req_type = REQ_PIXEL;
      else if (pick < 20) q.req_type = REQ_HLINE;
      else if (pick < 28) q.req_type = REQ_RECT;
      else if (pick < 36) q.req_type = REQ_GLYPH;
      else if (pick < 60) q.req_type = REQ_STRING;
      else if (pick < 98) q.req_type = REQ_READ;
      else                q.req_type = 3'd7;
      // Strings mostly use printable text so that the cursor walks the row.
      if (q.req_type == REQ_STRING && $urandom_range(3) != 0)
         q.char_code = 8'($urandom_range(CODE_HIGH, CODE_LOW));
      return q;
   endfunction

   // Hand one word to the block, with an optional idle gap first.
   task automatic send_word(input req_item_type q);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_percent) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= q;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      start        = 1'b0;
      reset        = 1'b1;
      req_item     = '0;
      idle_percent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: field extremes, each request kind, off-screen and wrap cases.
      send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 10'd0));
      send_word(make_word(REQ_PIXEL, 0, 0, 0, 0, 1, 0, 0, 0));
      send_word(make_word(REQ_PIXEL, 127, 63, 0, 0, 1, 0, 0, 0));
      send_word(make_word(REQ_PIXEL, -1, 128, 0, 0, 1, 0, 0, 0));
      send_word(make_word(REQ_PIXEL, 32767, -32768, 0, 0, 1, 0, 0, 0));
      send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 10'd1023));
      send_word(make_word(REQ_HLINE, 32767, 5, 10, 0, 1, 0, 0, 0));
      send_word(make_word(REQ_HLINE, 3, 9, 0, 0, 1, 0, 0, 0));
      send_word(make_word(REQ_HLINE, 3, 9, -32768, 0, 1, 0, 0, 0));
      send_word(make_word(REQ_RECT, 120, 60, 20, 0, 1, 0, 0, 0));
      send_word(make_word(REQ_RECT, -2, -2, 6, 8, 1, 0, 0, 0));
      send_word(make_word(REQ_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(REQ_GLYPH, 10, 20, 0, 0, 1, 8'h30, 0, 0));
      send_word(make_word(REQ_GLYPH, 124, 60, 0, 0, 0, 8'h7E, 0, 0));
      send_word(make_word(REQ_GLYPH, 40, 3, 0, 0, 1, 8'hFF, 0, 0));
      send_word(make_word(REQ_GLYPH, 50, 3, 0, 0, 1, 8'h1F, 0, 0));
      send_word(make_word(REQ_STRING, 110, 30, 0, 0, 1, 8'h41, 1, 0));
      send_word(make_word(REQ_STRING, 0, 30, 0, 0, 1, 8'h7F, 0, 0));
      send_word(make_word(REQ_STRING, 0, 30, 0, 0, 1, 8'h42, 0, 0));
      send_word(make_word(REQ_STRING, 0, 30, 0, 0, 1, 8'h43, 0, 0));
      send_word(make_word(REQ_STRING, 32767, 30, 0, 0, 1, 8'h43, 1, 0));
      send_word(make_word(3'd7, 0, 0, 0, 0, 1, 0, 0, 0));
      send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 10'd3));
      send_word(make_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 10'd0));

      // Random words in phases of different sender idling.
      for (int n = 0; n < 400; n++) begin
         case (n / 100)
            0:       idle_percent = 0;
            1:       idle_percent = 85;
            2:       idle_percent = 0;
            default: idle_percent = 29;
         endcase
         if (n == 200) drain();
         send_word(random_word());
      end
      drain();

      if (fail_count == 0) begin
         $display("mono_page_framebuffer_text_draw test passed");
      end else begin
         $display("mono_page_framebuffer_text_draw test failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4000000;
      $display("mono_page_framebuffer_text_draw test failed");
      $finish;
   end

endmodule
`default_nettype wire
